// ----- rtl/uvs_pkg.sv -----
// Shared constants, types and arithmetic helpers of the UV sphere cell tessellator.
package uvs_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int MAX_DIVISIONS  = 1024;
    localparam int INDEX_W        = 10;
    localparam int RADIUS_W       = 24;
    localparam int STEP_W         = 16;
    localparam int COORD_W        = 25;
    localparam int CORNER_W       = 3;
    localparam int CFG_ADDR_W     = 2;
    localparam int SINE_W         = 18;
    localparam int FRAC_W         = 31;
    localparam int NUM_LANES      = 4;
    localparam int NUM_HORNER     = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RADIUS       = 2'd0,
        REG_AZIMUTH_STEP = 2'd1,
        REG_POLAR_STEP   = 2'd2
    } cfg_reg_t;

    typedef logic [FRAC_W-1:0]   frac_t;
    typedef logic [CORNER_W-1:0] corner_t;
    typedef logic signed [SINE_W-1:0]  sine_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam corner_t LAST_CORNER = 3'd5;

    // Polynomial coefficients of sin(pi/2*x), Q2.30.
    localparam frac_t SC1 = 31'd1686629713;
    localparam frac_t SC3 = 31'd693598668;
    localparam frac_t SC5 = 31'd85569306;
    localparam frac_t SC7 = 31'd5026996;
    localparam frac_t SC9 = 31'd172271;

    localparam frac_t HORNER_COEF [NUM_HORNER] = '{SC7, SC5, SC3, SC1};

    typedef struct packed {
        frac_t      x;
        frac_t      x2;
        frac_t      p;
        logic [1:0] quad;
    } lane_t;

    // Reduces an index modulo MAX_DIVISIONS by conditional subtraction.
    function automatic logic [INDEX_W-1:0] reduce_index(input logic [INDEX_W-1:0] v);
        logic [INDEX_W-1:0] r;
        longint             lim;
        r = v;
        for (int k = INDEX_W - 1; k >= 0; k--) begin
            lim = longint'(MAX_DIVISIONS) << k;
            if (lim < (longint'(1) << INDEX_W) && longint'(r) >= lim) begin
                r = r - INDEX_W'(lim);
            end
        end
        return r;
    endfunction

    // Corners 1, 2 and 4 sit on the next polar row; 2, 4 and 5 on the next column.
    function automatic logic corner_uses_p1(input corner_t c);
        return (c == 3'd1) || (c == 3'd2) || (c == 3'd4);
    endfunction

    function automatic logic corner_uses_a1(input corner_t c);
        return (c == 3'd2) || (c == 3'd4) || (c == LAST_CORNER);
    endfunction

    // Splits a 32-bit turn into quadrant and folded Q0.30 fraction.
    function automatic lane_t sine_front(input logic [31:0] u);
        lane_t l;
        l.quad = u[31:30];
        l.x    = u[30] ? (31'h4000_0000 - {1'b0, u[29:0]}) : {1'b0, u[29:0]};
        l.x2   = '0;
        l.p    = '0;
        return l;
    endfunction

    // Rounds the Q2.30 magnitude to Q1.16, caps it at one and applies the sign.
    function automatic sine_t sine_round(input frac_t m, input logic [1:0] quad);
        logic [31:0]       s;
        logic [SINE_W-1:0] mag;
        s   = {1'b0, m} + 32'd8192;
        mag = s[31:14];
        if (mag > 18'd65536) begin
            mag = 18'd65536;
        end
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Q8.16 product on magnitudes, rounded half away from zero.
    function automatic coord_t q16_mul(input coord_t a, input sine_t b);
        logic [COORD_W-2:0] ma;
        logic [SINE_W-2:0]  mb;
        logic [41:0]        prod;
        logic [COORD_W-1:0] m;
        logic               neg;
        neg  = a[COORD_W-1] ^ b[SINE_W-1];
        ma   = a[COORD_W-1] ? 24'(-a) : a[COORD_W-2:0];
        mb   = b[SINE_W-1] ? 17'(-b) : b[SINE_W-2:0];
        prod = 42'(ma) * 42'(mb) + 42'd32768;
        m    = prod[40:16];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ----- rtl/uv_sphere_cell_tessellator.sv -----
// UV sphere cell tessellator: one cell in, six triangle vertices out.
// The issue stage steps through the six corners of a cell; the result channel carries one
// vertex per transfer and every cell yields six, so cells are accepted back to back, a new
// cell as the last corner of the one before is issued. The path is a chain of registered cells
// (phase fold, square, four Horner steps, final multiply, rounding, two Q8.16 products)
// that all advance together, and the whole chain holds while a finished vertex is not taken.
// Configuration writes take effect at once and should only be made while the block is idle.
module uv_sphere_cell_tessellator #(
    parameter int PHASE_BITS = uvs_pkg::PHASE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [uvs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uvs_pkg::RADIUS_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [uvs_pkg::INDEX_W-1:0]   s_polar_index,
    input  logic [uvs_pkg::INDEX_W-1:0]   s_azimuth_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [uvs_pkg::COORD_W-1:0] m_coord_x,
    output logic signed [uvs_pkg::COORD_W-1:0] m_coord_y,
    output logic signed [uvs_pkg::COORD_W-1:0] m_coord_z,
    output logic [uvs_pkg::CORNER_W-1:0]  m_corner_number,
    output logic                          m_last_of_cell
);
    import uvs_pkg::*;

    localparam int DEPTH = 10;
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

    logic [RADIUS_W-1:0] radius_reg;
    logic [STEP_W-1:0]   az_step_reg;
    logic [STEP_W-1:0]   pol_step_reg;

    logic                  adv;
    logic                  iss_valid;
    logic [PHASE_BITS-1:0] iss_pp, iss_ap;
    corner_t               iss_corner;

    logic    vld_reg    [1:DEPTH];
    corner_t corner_reg [1:DEPTH];

    lane_t st1_reg [NUM_LANES];
    lane_t st2_reg [NUM_LANES];
    lane_t hc [NUM_HORNER+1][NUM_LANES];
    frac_t      mag_reg  [NUM_LANES];
    logic [1:0] quad_reg [NUM_LANES];
    sine_t      sine_reg [NUM_LANES];

    coord_t rs_reg, y9_reg;
    sine_t  sa_reg, ca_reg;
    coord_t x_reg, y_reg, z_reg;

    logic [PHASE_BITS-1:0] lane_phase [NUM_LANES];

    // Lanes: sine and cosine of the polar phase, then of the azimuth phase.
    assign lane_phase[0] = iss_pp;
    assign lane_phase[1] = iss_pp + QUARTER;
    assign lane_phase[2] = iss_ap;
    assign lane_phase[3] = iss_ap + QUARTER;

    assign adv = !vld_reg[DEPTH] || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= RADIUS_W'(65536);
            az_step_reg  <= STEP_W'(4096);
            pol_step_reg <= STEP_W'(4096);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RADIUS:       radius_reg   <= cfg_wdata;
                REG_AZIMUTH_STEP: az_step_reg  <= cfg_wdata[STEP_W-1:0];
                REG_POLAR_STEP:   pol_step_reg <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    uvs_issue #(
        .PHASE_BITS(PHASE_BITS)
    ) u_issue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (adv),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_polar_index    (s_polar_index),
        .s_azimuth_index  (s_azimuth_index),
        .polar_step       (pol_step_reg),
        .azimuth_step     (az_step_reg),
        .iss_valid        (iss_valid),
        .iss_polar_phase  (iss_pp),
        .iss_azimuth_phase(iss_ap),
        .iss_corner       (iss_corner)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[1] <= iss_valid;
            for (int i = 2; i <= DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            corner_reg[1] <= iss_corner;
            for (int i = 2; i <= DEPTH; i++) begin
                corner_reg[i] <= corner_reg[i-1];
            end
        end
    end

    // Fold the phase into a quadrant and a fraction, then square the fraction.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int ln = 0; ln < NUM_LANES; ln++) begin
                st1_reg[ln] <= sine_front(32'(lane_phase[ln]) << (32 - PHASE_BITS));
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [61:0] sq;
        if (adv) begin
            for (int ln = 0; ln < NUM_LANES; ln++) begin
                sq = 62'(st1_reg[ln].x) * 62'(st1_reg[ln].x);
                st2_reg[ln].x    <= st1_reg[ln].x;
                st2_reg[ln].quad <= st1_reg[ln].quad;
                st2_reg[ln].x2   <= sq[60:30];
                st2_reg[ln].p    <= SC9;
            end
        end
    end

    for (genvar ln = 0; ln < NUM_LANES; ln++) begin : g_lane
        assign hc[0][ln] = st2_reg[ln];
        for (genvar s = 0; s < NUM_HORNER; s++) begin : g_step
            uvs_horner_cell #(
                .COEF(HORNER_COEF[s])
            ) u_cell (
                .aclk  (aclk),
                .en    (adv),
                .lane_i(hc[s][ln]),
                .lane_o(hc[s+1][ln])
            );
        end
    end

    always_ff @(posedge aclk) begin
        logic [61:0] mp;
        if (adv) begin
            for (int ln = 0; ln < NUM_LANES; ln++) begin
                mp = 62'(hc[NUM_HORNER][ln].x) * 62'(hc[NUM_HORNER][ln].p);
                mag_reg[ln]  <= mp[60:30];
                quad_reg[ln] <= hc[NUM_HORNER][ln].quad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int ln = 0; ln < NUM_LANES; ln++) begin
                sine_reg[ln] <= sine_round(mag_reg[ln], quad_reg[ln]);
            end
        end
    end

    // r*sin(p) and r*cos(p), then the azimuth products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rs_reg <= q16_mul(coord_t'({1'b0, radius_reg}), sine_reg[0]);
            y9_reg <= q16_mul(coord_t'({1'b0, radius_reg}), sine_reg[1]);
            sa_reg <= sine_reg[2];
            ca_reg <= sine_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= q16_mul(rs_reg, sa_reg);
            y_reg <= y9_reg;
            z_reg <= q16_mul(rs_reg, ca_reg);
        end
    end

    assign m_valid         = vld_reg[DEPTH];
    assign m_coord_x       = x_reg;
    assign m_coord_y       = y_reg;
    assign m_coord_z       = z_reg;
    assign m_corner_number = corner_reg[DEPTH];
    assign m_last_of_cell  = (corner_reg[DEPTH] == LAST_CORNER);

endmodule

// ----- rtl/uvs_horner_cell.sv -----
// One Horner step of the sine polynomial: p_next = COEF - (x2 * p) >> 30, registered.
module uvs_horner_cell #(
    parameter uvs_pkg::frac_t COEF = uvs_pkg::SC7
) (
    input  logic           aclk,
    input  logic           en,
    input  uvs_pkg::lane_t lane_i,
    output uvs_pkg::lane_t lane_o
);
    import uvs_pkg::*;

    lane_t       lane_reg;
    lane_t       lane_next;
    logic [61:0] prod;

    always_comb begin
        prod      = 62'(lane_i.x2) * 62'(lane_i.p);
        lane_next = lane_i;
        lane_next.p = COEF - prod[60:30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

// ----- rtl/uvs_issue.sv -----
// Cell sequencer: takes one cell, forms its four phases and steps through six corners.
module uvs_issue #(
    parameter int PHASE_BITS = uvs_pkg::PHASE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [uvs_pkg::INDEX_W-1:0]     s_polar_index,
    input  logic [uvs_pkg::INDEX_W-1:0]     s_azimuth_index,
    input  logic [uvs_pkg::STEP_W-1:0]      polar_step,
    input  logic [uvs_pkg::STEP_W-1:0]      azimuth_step,
    output logic                            iss_valid,
    output logic [PHASE_BITS-1:0]           iss_polar_phase,
    output logic [PHASE_BITS-1:0]           iss_azimuth_phase,
    output uvs_pkg::corner_t                iss_corner
);
    import uvs_pkg::*;

    logic                  busy_reg, busy_next;
    corner_t               cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0] p0_reg, p1_reg, a0_reg, a1_reg;
    logic [PHASE_BITS-1:0] p0_next, a0_next;
    logic [25:0]           p_prod, a_prod;
    logic                  accept;
    logic                  finishing;

    assign finishing = busy_reg && en && (cnt_reg == LAST_CORNER);
    assign s_ready   = !busy_reg || finishing;
    assign accept    = s_valid && s_ready;

    always_comb begin
        p_prod  = 26'(reduce_index(s_polar_index)) * 26'(polar_step);
        a_prod  = 26'(reduce_index(s_azimuth_index)) * 26'(azimuth_step);
        p0_next = PHASE_BITS'(p_prod);
        a0_next = PHASE_BITS'(a_prod);
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (finishing) begin
            busy_next = 1'b0;
        end else if (busy_reg && en) begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p0_reg <= p0_next;
            p1_reg <= p0_next + PHASE_BITS'(polar_step);
            a0_reg <= a0_next;
            a1_reg <= a0_next + PHASE_BITS'(azimuth_step);
        end
    end

    assign iss_valid         = busy_reg;
    assign iss_corner        = cnt_reg;
    assign iss_polar_phase   = corner_uses_p1(cnt_reg) ? p1_reg : p0_reg;
    assign iss_azimuth_phase = corner_uses_a1(cnt_reg) ? a1_reg : a0_reg;

endmodule

// ----- test/tb_uv_sphere_cell_tessellator.sv -----
// Self-checking testbench of the UV sphere cell tessellator: directed and random cells.
`timescale 1ns / 100ps

module tb_uv_sphere_cell_tessellator;
    import uvs_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        coord_t  x;
        coord_t  y;
        coord_t  z;
        corner_t corner;
        logic    last;
    } vertex_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [RADIUS_W-1:0]   cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [INDEX_W-1:0]    s_polar_index;
    logic [INDEX_W-1:0]    s_azimuth_index;
    logic                  m_valid;
    logic                  m_ready;
    coord_t                m_coord_x;
    coord_t                m_coord_y;
    coord_t                m_coord_z;
    corner_t               m_corner_number;
    logic                  m_last_of_cell;

    // Local copy of the block's registers.
    logic [RADIUS_W-1:0] radius;
    logic [STEP_W-1:0]   az_step;
    logic [STEP_W-1:0]   pol_step;

    vertex_t pending_vertices[$];
    int      error_count;
    int      cells_sent;
    int      vertices_seen;
    bit      sender_busy_mode;
    bit      receiver_busy_mode;

    uv_sphere_cell_tessellator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_polar_index   (s_polar_index),
        .s_azimuth_index (s_azimuth_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_coord_x       (m_coord_x),
        .m_coord_y       (m_coord_y),
        .m_coord_z       (m_coord_z),
        .m_corner_number (m_corner_number),
        .m_last_of_cell  (m_last_of_cell)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("uv_sphere_cell_tessellator: mismatch");
        $finish;
    end

    // Sine of a 16-bit phase in Q1.16, by the folded odd polynomial.
    function automatic longint sine_q16(input logic [15:0] phase);
        logic [31:0]     u;
        logic [1:0]      quad;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned mag;
        u    = {phase, 16'h0000};
        quad = u[31:30];
        x    = quad[0] ? ((64'd1 << 30) - u[29:0]) : u[29:0];
        x2   = (x * x) >> 30;
        p    = SC9;
        p    = SC7 - ((x2 * p) >> 30);
        p    = SC5 - ((x2 * p) >> 30);
        p    = SC3 - ((x2 * p) >> 30);
        p    = SC1 - ((x2 * p) >> 30);
        mag  = (x * p) >> 30;
        mag  = (mag + (64'd1 << 13)) >> 14;
        if (mag > 65536) begin
            mag = 65536;
        end
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // Q8.16 product on magnitudes, rounded half away from zero.
    function automatic longint scale_q16(input longint a, input longint b);
        longint m;
        m = (((a < 0) ? -a : a) * ((b < 0) ? -b : b) + 32768) >>> 16;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic vertex_t sphere_point(input logic [15:0] pp, input logic [15:0] ap,
                                             input int k);
        vertex_t v;
        longint  rs;
        rs       = scale_q16(radius, sine_q16(pp));
        v.x      = coord_t'(scale_q16(rs, sine_q16(ap)));
        v.y      = coord_t'(scale_q16(radius, sine_q16(pp + 16'h4000)));
        v.z      = coord_t'(scale_q16(rs, sine_q16(ap + 16'h4000)));
        v.corner = corner_t'(k);
        v.last   = (k == 5);
        return v;
    endfunction

    // Queues the six corners of a cell in triangle order v1,v3,v2,v1,v2,v4.
    task automatic predict_cell(input logic [INDEX_W-1:0] pi, input logic [INDEX_W-1:0] ai);
        logic [15:0] p0;
        logic [15:0] p1;
        logic [15:0] a0;
        logic [15:0] a1;
        p0 = 16'(pi * pol_step);
        p1 = p0 + pol_step;
        a0 = 16'(ai * az_step);
        a1 = a0 + az_step;
        pending_vertices.push_back(sphere_point(p0, a0, 0));
        pending_vertices.push_back(sphere_point(p1, a0, 1));
        pending_vertices.push_back(sphere_point(p1, a1, 2));
        pending_vertices.push_back(sphere_point(p0, a0, 3));
        pending_vertices.push_back(sphere_point(p1, a1, 4));
        pending_vertices.push_back(sphere_point(p0, a1, 5));
    endtask

    function automatic int pick_gap();
        if (!sender_busy_mode) begin
            return 0;
        end
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 25);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Sends one cell; returns at the edge of its transfer with valid still high.
    task automatic send_cell(input logic [INDEX_W-1:0] pi, input logic [INDEX_W-1:0] ai);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_polar_index   <= pi;
        s_azimuth_index <= ai;
        do @(posedge aclk); while (!s_ready);
        predict_cell(pi, ai);
        cells_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [RADIUS_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_RADIUS:       radius   = val;
            REG_AZIMUTH_STEP: az_step  = val[STEP_W-1:0];
            REG_POLAR_STEP:   pol_step = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Drains the block, then writes all three registers and one unused index.
    task automatic configure(input logic [RADIUS_W-1:0] r, input logic [STEP_W-1:0] az,
                             input logic [STEP_W-1:0] pol);
        drain();
        write_reg(REG_RADIUS, r);
        write_reg(REG_AZIMUTH_STEP, RADIUS_W'(az));
        write_reg(REG_UNUSED, RADIUS_W'($urandom()));
        write_reg(REG_POLAR_STEP, RADIUS_W'(pol));
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_cell(10'd0, 10'd0);
        send_cell(10'd1023, 10'd1023);
        send_cell(10'd15, 10'd3);
        send_cell(10'd16, 10'd512);
        send_cell(10'h155, 10'h2AA);
        send_cell(10'h2AA, 10'h155);
    endtask

    task automatic test_register_extremes();
        configure(24'hFFFFFF, 16'hFFFF, 16'h8000);
        send_cell(10'd0, 10'd0);
        send_cell(10'd1, 10'd1023);
        send_cell(10'd1023, 10'd1);
        configure(24'd0, 16'd0, 16'd0);
        send_cell(10'd7, 10'd9);
        send_cell(10'd1023, 10'd1023);
        // A polar step past a half turn makes sin(p) negative.
        configure(24'd98304, 16'd1000, 16'hFFFF);
        send_cell(10'd0, 10'd0);
        send_cell(10'd1, 10'd64);
        send_cell(10'd1023, 10'd700);
        configure(24'd65536, 16'd6554, 16'd3277);
        send_cell(10'd9, 10'd9);
        send_cell(10'd10, 10'd1023);
    endtask

    task automatic test_random_cells();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(24'd65536, 16'd1024, 16'd2048);
                1: configure(24'hFFFFFF, 16'($urandom()), 16'($urandom_range(0, 32768)));
                2: configure(24'($urandom()), 16'($urandom()), 16'($urandom()));
                3: configure(24'd1, 16'd64, 16'd32);
                default: configure(24'($urandom()), 16'($urandom()),
                                   16'($urandom_range(0, 32768)));
            endcase
            sender_busy_mode = (phase != 3);
            for (int n = 0; n < 58; n++) begin
                send_cell(INDEX_W'($urandom()), INDEX_W'($urandom()));
                if (n == 30) begin
                    drain();
                end
            end
        end
    endtask

    // Result side: random stalls, with stretches of none.
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) begin
            receiver_busy_mode <= ~receiver_busy_mode;
        end
        if (!receiver_busy_mode) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
            m_ready <= 1'b0;
        end else if (!m_ready) begin
            m_ready <= ($urandom_range(0, 5) == 0);
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        vertex_t want;
        if (aresetn && m_valid && m_ready) begin
            vertices_seen++;
            if (pending_vertices.size() == 0) begin
                report_mismatch("unexpected vertex, corner", m_corner_number, -1);
            end else begin
                want = pending_vertices.pop_front();
                if (m_coord_x !== want.x) report_mismatch("coord_x", m_coord_x, want.x);
                if (m_coord_y !== want.y) report_mismatch("coord_y", m_coord_y, want.y);
                if (m_coord_z !== want.z) report_mismatch("coord_z", m_coord_z, want.z);
                if (m_corner_number !== want.corner) begin
                    report_mismatch("corner_number", m_corner_number, want.corner);
                end
                if (m_last_of_cell !== want.last) begin
                    report_mismatch("last_of_cell", m_last_of_cell, want.last);
                end
            end
        end
    end

    initial begin
        aresetn            = 1'b0;
        cfg_we             = 1'b0;
        cfg_addr           = REG_RADIUS;
        cfg_wdata          = '0;
        s_valid            = 1'b0;
        s_polar_index      = '0;
        s_azimuth_index    = '0;
        m_ready            = 1'b0;
        receiver_busy_mode = 1'b1;
        sender_busy_mode   = 1'b1;
        error_count        = 0;
        cells_sent         = 0;
        vertices_seen      = 0;
        radius             = 24'd65536;
        az_step            = 16'd4096;
        pol_step           = 16'd4096;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_extremes();
        test_random_cells();
        drain();

        $display("Sent %0d cells and checked %0d vertices over several register settings,",
                 cells_sent, vertices_seen);
        $display("including zero and full-scale radius and steps; %0d errors.", error_count);
        if (error_count == 0 && pending_vertices.size() == 0) begin
            $display("uv_sphere_cell_tessellator: match");
        end else begin
            $display("uv_sphere_cell_tessellator: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/uvs_pkg.sv
rtl/uvs_horner_cell.sv
rtl/uvs_issue.sv
rtl/uv_sphere_cell_tessellator.sv
test/tb_uv_sphere_cell_tessellator.sv
